// ===== hdl/lpts_pkg.sv =====
package lpts_pkg;

  localparam int unsigned MaxSlicesDef = 16;
  localparam int unsigned SidxMaxW     = 8;
  localparam int unsigned IdxW         = 20;
  localparam int unsigned CoordW       = 19;
  localparam int unsigned TimeW        = 28;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned RangeW       = 40;
  localparam int unsigned SqW          = 37;
  localparam int unsigned R2W          = 39;
  localparam int unsigned FracW        = 17;
  localparam int unsigned CountW       = 5;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 40;

  localparam logic [ByteW-1:0]  TagMask     = 8'h30;
  localparam logic [ByteW-1:0]  TagAllowedA = 8'h00;
  localparam logic [ByteW-1:0]  TagAllowedB = 8'h10;
  localparam logic [FracW-1:0]  FracSat     = 17'd131071;

  localparam logic [ByteW-1:0]  DecimateRst = 8'd1;
  localparam logic [RangeW-1:0] MinRangeRst = 40'd0;
  localparam logic [RangeW-1:0] MaxRangeRst = 40'd22500000000;
  localparam logic [CountW-1:0] CountRst    = 5'd1;
  localparam logic [TimeW-1:0]  WidthRst    = 28'd100000000;

  typedef enum logic [CfgIdxW-1:0] {
    RegDecimate = 3'd0,
    RegMinRange = 3'd1,
    RegMaxRange = 3'd2,
    RegTagCheck = 3'd3,
    RegSliceCnt = 3'd4,
    RegSliceW   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0]    step;
    logic [RangeW-1:0]   min_r2;
    logic [RangeW-1:0]   max_r2;
    logic                tag_en;
    logic [SidxMaxW-1:0] cnt_m1;
    logic [TimeW-1:0]    width;
  } cfg_t;

  typedef struct packed {
    logic                     ok;
    logic                     rng_ok;
    logic [IdxW-1:0]          idx;
    logic [ByteW-1:0]         mrem;
    logic [TimeW-1:0]         t;
    logic [SidxMaxW-1:0]      q;
    logic                     big;
    logic [SqW-1:0]           sqx;
    logic [SqW-1:0]           sqy;
    logic [SqW-1:0]           sqz;
    logic [R2W-1:0]           r2;
    logic [TimeW:0]           prem;
    logic [FracW-1:0]         frac;
    logic                     sat;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [ByteW-1:0]         refl;
    logic [ByteW-1:0]         ring;
  } pt_t;

endpackage

// ===== hdl/lpts_in_if.sv =====
interface lpts_in_if;
  import lpts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     coords_finite;
  logic [IdxW-1:0]          point_index;
  logic signed [CoordW-1:0] x_mm;
  logic signed [CoordW-1:0] y_mm;
  logic signed [CoordW-1:0] z_mm;
  logic [TimeW-1:0]         offset_ns;
  logic [ByteW-1:0]         tag_bits;
  logic [ByteW-1:0]         reflect_level;
  logic [ByteW-1:0]         ring_number;

  modport source (output valid, coords_finite, point_index, x_mm, y_mm, z_mm, offset_ns,
                  tag_bits, reflect_level, ring_number, input ready);
  modport sink (input valid, coords_finite, point_index, x_mm, y_mm, z_mm, offset_ns,
                tag_bits, reflect_level, ring_number, output ready);
endinterface

// ===== hdl/lpts_out_if.sv =====
interface lpts_out_if #(
  parameter int unsigned SIDX_W = 4
);
  import lpts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     keep;
  logic [SIDX_W-1:0]        slice_index;
  logic [FracW-1:0]         slice_fraction_q16;
  logic signed [CoordW-1:0] out_x_mm;
  logic signed [CoordW-1:0] out_y_mm;
  logic signed [CoordW-1:0] out_z_mm;
  logic [TimeW-1:0]         out_offset_ns;
  logic [ByteW-1:0]         out_reflect;
  logic [ByteW-1:0]         out_ring;

  modport source (output valid, keep, slice_index, slice_fraction_q16, out_x_mm, out_y_mm,
                  out_z_mm, out_offset_ns, out_reflect, out_ring, input ready);
  modport sink (input valid, keep, slice_index, slice_fraction_q16, out_x_mm, out_y_mm,
                out_z_mm, out_offset_ns, out_reflect, out_ring, output ready);
endinterface

// ===== hdl/lpts_cfg_if.sv =====
interface lpts_cfg_if;
  import lpts_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/lpts_cfg.sv =====
module lpts_cfg #(
  parameter int unsigned MAX_SLICES = lpts_pkg::MaxSlicesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lpts_cfg_if.sink       cfg_i,
  output lpts_pkg::cfg_t cfg_o
);
  import lpts_pkg::*;

  logic [ByteW-1:0]  decim_q;
  logic [RangeW-1:0] min_q, max_q;
  logic              tag_q;
  logic [CountW-1:0] cnt_q;
  logic [TimeW-1:0]  width_q;
  logic [8:0]        cnt_c;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= DecimateRst;
      min_q   <= MinRangeRst;
      max_q   <= MaxRangeRst;
      tag_q   <= 1'b0;
      cnt_q   <= CountRst;
      width_q <= WidthRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegDecimate: decim_q <= cfg_i.data[ByteW-1:0];
        RegMinRange: min_q   <= cfg_i.data[RangeW-1:0];
        RegMaxRange: max_q   <= cfg_i.data[RangeW-1:0];
        RegTagCheck: tag_q   <= cfg_i.data[0];
        RegSliceCnt: cnt_q   <= cfg_i.data[CountW-1:0];
        RegSliceW:   width_q <= cfg_i.data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_c = {4'd0, cnt_q};
    if (cnt_c == 9'd0) cnt_c = 9'd1;
    if (cnt_c > 9'(MAX_SLICES)) cnt_c = 9'(MAX_SLICES);
    cfg_o.step   = (decim_q == '0) ? ByteW'(1) : decim_q;
    cfg_o.min_r2 = min_q;
    cfg_o.max_r2 = max_q;
    cfg_o.tag_en = tag_q;
    cfg_o.cnt_m1 = SidxMaxW'(cnt_c - 9'd1);
    cfg_o.width  = (width_q == '0) ? TimeW'(1) : width_q;
  end
endmodule

// ===== hdl/lpts_front.sv =====
module lpts_front #(
  parameter int unsigned SIDX_W = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  lpts_pkg::cfg_t cfg_i,
  lpts_in_if.sink        in_i,
  output logic           vld_o,
  output lpts_pkg::pt_t  pt_o
);
  import lpts_pkg::*;

  logic          v1_q, v2_q, v3_q;
  pt_t           p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [2*CoordW-1:0] sx, sy, sz;
  logic [ByteW-1:0]      tb;
  logic [TimeW+SIDX_W-1:0] r;
  logic [SIDX_W-1:0]     qc;
  logic [TimeW+SIDX_W-1:0] prod;

  assign in_i.ready = en_i;

  always_comb begin
    sx = in_i.x_mm * in_i.x_mm;
    sy = in_i.y_mm * in_i.y_mm;
    sz = in_i.z_mm * in_i.z_mm;
    tb = in_i.tag_bits & TagMask;
    p1_d      = '0;
    p1_d.ok   = in_i.coords_finite &&
                (!cfg_i.tag_en || tb == TagAllowedA || tb == TagAllowedB);
    p1_d.idx  = in_i.point_index;
    p1_d.t    = in_i.offset_ns;
    p1_d.sqx  = sx[SqW-1:0];
    p1_d.sqy  = sy[SqW-1:0];
    p1_d.sqz  = sz[SqW-1:0];
    p1_d.x    = in_i.x_mm;
    p1_d.y    = in_i.y_mm;
    p1_d.z    = in_i.z_mm;
    p1_d.refl = in_i.reflect_level;
    p1_d.ring = in_i.ring_number;
  end

  always_comb begin
    p2_d     = p1_q;
    p2_d.r2  = R2W'(p1_q.sqx) + R2W'(p1_q.sqy) + R2W'(p1_q.sqz);
    p2_d.big = {TimeW'(0), p1_q.t} >= {cfg_i.width, SIDX_W'(0)};
    p2_d.q   = '0;
    r        = (TimeW+SIDX_W)'(p1_q.t);
    for (int b = SIDX_W - 1; b >= 0; b--) begin
      if (r >= ((TimeW+SIDX_W)'(cfg_i.width) << b)) begin
        r       = r - ((TimeW+SIDX_W)'(cfg_i.width) << b);
        p2_d.q[b] = 1'b1;
      end
    end
  end

  always_comb begin
    p3_d        = p2_q;
    p3_d.rng_ok = ({1'b0, p2_q.r2} >= cfg_i.min_r2) && ({1'b0, p2_q.r2} <= cfg_i.max_r2);
    qc          = (p2_q.big || p2_q.q[SIDX_W-1:0] > cfg_i.cnt_m1[SIDX_W-1:0]) ?
                  cfg_i.cnt_m1[SIDX_W-1:0] : p2_q.q[SIDX_W-1:0];
    prod        = (TimeW+SIDX_W)'(qc) * (TimeW+SIDX_W)'(cfg_i.width);
    p3_d.q      = SidxMaxW'(qc);
    p3_d.prem   = {1'b0, p2_q.t - prod[TimeW-1:0]};
    p3_d.sat    = p3_d.prem >= {cfg_i.width, 1'b0};
    p3_d.mrem   = '0;
    p3_d.frac   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  assign vld_o = v3_q;
  assign pt_o  = p3_q;
endmodule

// ===== hdl/lpts_div_stage.sv =====
module lpts_div_stage #(
  parameter bit          FIRST      = 1'b0,
  parameter int unsigned FRAC_STEPS = 4,
  parameter int unsigned MOD_STEPS  = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  lpts_pkg::cfg_t cfg_i,
  input  logic           vld_i,
  input  lpts_pkg::pt_t  pt_i,
  output logic           vld_o,
  output lpts_pkg::pt_t  pt_o
);
  import lpts_pkg::*;

  logic          vld_q;
  pt_t           pt_q, pt_d;
  logic [ByteW:0] p9;
  logic [TimeW:0] p2;

  always_comb begin
    pt_d = pt_i;
    for (int i = 0; i < MOD_STEPS; i++) begin
      p9       = {pt_d.mrem, pt_d.idx[IdxW-1]};
      pt_d.idx = {pt_d.idx[IdxW-2:0], 1'b0};
      if (p9 >= {1'b0, cfg_i.step}) p9 = p9 - {1'b0, cfg_i.step};
      pt_d.mrem = p9[ByteW-1:0];
    end
    for (int i = 0; i < FRAC_STEPS; i++) begin
      if (FIRST && i == 0) p2 = pt_d.prem;
      else                 p2 = {pt_d.prem[TimeW-1:0], 1'b0};
      if (p2 >= {1'b0, cfg_i.width}) begin
        p2        = p2 - {1'b0, cfg_i.width};
        pt_d.frac = {pt_d.frac[FracW-2:0], 1'b1};
      end else begin
        pt_d.frac = {pt_d.frac[FracW-2:0], 1'b0};
      end
      pt_d.prem = p2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pt_q <= pt_d;
  end

  assign vld_o = vld_q;
  assign pt_o  = pt_q;
endmodule

// ===== hdl/lidar_point_filter_time_slicer_top.sv =====
// Lidar point filter and time slicer. One point is taken per clock cycle while the output is
// not stalled, and each point gives exactly one result word. The path runs through three front
// stages (squares and tag test, range sum and slice quotient, clamp and remainder), five
// stages of the two restoring dividers (index modulo decimation step, and the 17-bit slice
// fraction, about four quotient bits to a stage) and the output register. A stall at the
// output holds the whole pipeline. Configuration writes are taken at any time but must only
// be made while no point is in flight.
module lidar_point_filter_time_slicer_top #(
  parameter int unsigned MAX_SLICES = lpts_pkg::MaxSlicesDef,
  parameter int unsigned SIDX_W     = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpts_in_if.sink   in_i,
  lpts_cfg_if.sink  cfg_i,
  lpts_out_if.source out_o
);
  import lpts_pkg::*;

  localparam int unsigned NDiv = 5;

  cfg_t cfg;
  logic en;
  logic out_vld_q;
  logic keep;
  logic dv [NDiv+1];
  pt_t  dp [NDiv+1];

  assign en = !out_vld_q || out_o.ready;

  lpts_cfg #(.MAX_SLICES(MAX_SLICES)) u_cfg (
    .clk_i, .rst_ni, .cfg_i, .cfg_o(cfg)
  );

  lpts_front #(.SIDX_W(SIDX_W)) u_front (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg), .in_i, .vld_o(dv[0]), .pt_o(dp[0])
  );

  for (genvar s = 0; s < NDiv; s++) begin : g_div
    lpts_div_stage #(
      .FIRST      (s == 0),
      .FRAC_STEPS ((s == NDiv - 1) ? 1 : 4),
      .MOD_STEPS  (4)
    ) u_stage (
      .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg),
      .vld_i(dv[s]), .pt_i(dp[s]), .vld_o(dv[s+1]), .pt_o(dp[s+1])
    );
  end

  assign keep = dp[NDiv].ok && dp[NDiv].rng_ok && (dp[NDiv].mrem == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.keep               <= keep;
      out_o.slice_index        <= keep ? dp[NDiv].q[SIDX_W-1:0] : '0;
      out_o.slice_fraction_q16 <= !keep ? '0 : (dp[NDiv].sat ? FracSat : dp[NDiv].frac);
      out_o.out_x_mm           <= dp[NDiv].x;
      out_o.out_y_mm           <= dp[NDiv].y;
      out_o.out_z_mm           <= dp[NDiv].z;
      out_o.out_offset_ns      <= dp[NDiv].t;
      out_o.out_reflect        <= dp[NDiv].refl;
      out_o.out_ring           <= dp[NDiv].ring;
    end
  end

  assign out_o.valid = out_vld_q;

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.keep |-> out_o.slice_index == '0 && out_o.slice_fraction_q16 == '0)
    else $error("dropped word carries slice data");

  a_idx_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.keep |-> out_o.slice_index <= cfg.cnt_m1[SIDX_W-1:0])
    else $error("slice index past last slice");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without output back-pressure");
endmodule

// ===== sim/tb_lidar_point_filter_time_slicer_top.sv =====
`timescale 1ns / 100ps

module tb_lidar_point_filter_time_slicer_top;
  import lpts_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned PendDepth = 64;
  localparam int unsigned NumVecs = 8;

  typedef struct {
    bit                     finite;
    bit [IdxW-1:0]          idx;
    bit signed [CoordW-1:0] x;
    bit signed [CoordW-1:0] y;
    bit signed [CoordW-1:0] z;
    bit [TimeW-1:0]         t;
    bit [ByteW-1:0]         tag;
    bit [ByteW-1:0]         refl;
    bit [ByteW-1:0]         ring;
  } point_t;

  typedef struct {
    bit                     keep;
    bit [3:0]               sidx;
    bit [FracW-1:0]         frac;
    bit signed [CoordW-1:0] x;
    bit signed [CoordW-1:0] y;
    bit signed [CoordW-1:0] z;
    bit [TimeW-1:0]         t;
    bit [ByteW-1:0]         refl;
    bit [ByteW-1:0]         ring;
  } slice_res_t;

  typedef struct {
    point_t         p;
    bit             known;
    bit             keep;
    bit [3:0]       sidx;
    bit [FracW-1:0] frac;
  } vector_t;

  logic clk_i;
  logic rst_ni;

  lpts_in_if  in_if ();
  lpts_cfg_if cfg_if ();
  lpts_out_if #(.SIDX_W(4)) out_if ();

  lidar_point_filter_time_slicer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  bit [ByteW-1:0]  step_r;
  bit [RangeW-1:0] min_r2_r;
  bit [RangeW-1:0] max_r2_r;
  bit              tag_en_r;
  bit [CountW-1:0] count_r;
  bit [TimeW-1:0]  width_r;

  slice_res_t  pend_mem [PendDepth];
  int unsigned pend_wr;
  int unsigned pend_rd;
  bit          failed;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_cnt;
  int          quiet_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic slice_res_t slice_point(point_t p);
    slice_res_t r;
    longint unsigned step, cnt, wid, r2, q, rem, frac;
    longint signed sx, sy, sz;
    step = (step_r == 0) ? 1 : step_r;
    cnt  = (count_r == 0) ? 1 : ((count_r > MaxSlicesDef) ? MaxSlicesDef : count_r);
    wid  = (width_r == 0) ? 1 : width_r;
    sx = p.x;
    sy = p.y;
    sz = p.z;
    r2 = sx * sx + sy * sy + sz * sz;
    r.keep = p.finite && (p.idx % step == 0) && (r2 >= min_r2_r) && (r2 <= max_r2_r) &&
             (!tag_en_r || (p.tag & TagMask) == TagAllowedA || (p.tag & TagMask) == TagAllowedB);
    r.sidx = '0;
    r.frac = '0;
    if (r.keep) begin
      q = p.t / wid;
      if (q >= cnt) q = cnt - 1;
      rem  = p.t - q * wid;
      frac = (rem << 16) / wid;
      if (frac > FracSat) frac = FracSat;
      r.sidx = q[3:0];
      r.frac = frac[FracW-1:0];
    end
    r.x = p.x;
    r.y = p.y;
    r.z = p.z;
    r.t = p.t;
    r.refl = p.refl;
    r.ring = p.ring;
    return r;
  endfunction

  task automatic send_point(point_t p, bit known, bit k, bit [3:0] si, bit [FracW-1:0] fr);
    slice_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.coords_finite <= p.finite;
    in_if.point_index   <= p.idx;
    in_if.x_mm          <= p.x;
    in_if.y_mm          <= p.y;
    in_if.z_mm          <= p.z;
    in_if.offset_ns     <= p.t;
    in_if.tag_bits      <= p.tag;
    in_if.reflect_level <= p.refl;
    in_if.ring_number   <= p.ring;
    do @(posedge clk_i); while (!in_if.ready);
    r = slice_point(p);
    if (known) begin
      r.keep = k;
      r.sidx = si;
      r.frac = fr;
    end
    pend_mem[pend_wr % PendDepth] = r;
    pend_wr++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      RegDecimate: step_r   = val[ByteW-1:0];
      RegMinRange: min_r2_r = val[RangeW-1:0];
      RegMaxRange: max_r2_r = val[RangeW-1:0];
      RegTagCheck: tag_en_r = val[0];
      RegSliceCnt: count_r  = val[CountW-1:0];
      RegSliceW:   width_r  = val[TimeW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_all(bit [7:0] st, bit [39:0] mn, bit [39:0] mx, bit te,
                           bit [4:0] cn, bit [27:0] wd);
    write_reg(RegDecimate, CfgDataW'(st));
    write_reg(RegMinRange, CfgDataW'(mn));
    write_reg(RegMaxRange, CfgDataW'(mx));
    write_reg(RegTagCheck, CfgDataW'(te));
    write_reg(RegSliceCnt, CfgDataW'(cn));
    write_reg(RegSliceW, CfgDataW'(wd));
  endtask

  function automatic bit signed [CoordW-1:0] rand_coord();
    case ($urandom_range(3))
      0:       return CoordW'($urandom);
      1:       return CoordW'($urandom_range(2000)) - CoordW'(1000);
      default: return CoordW'($urandom_range(200000)) - CoordW'(100000);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    longint unsigned span;
    p.finite = ($urandom_range(9) != 0);
    p.idx = IdxW'($urandom);
    if ($urandom_range(3) != 0 && step_r > 1)
      p.idx = IdxW'(step_r * $urandom_range(4000));
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    span = longint'(width_r == 0 ? 1 : width_r) * (count_r == 0 ? 1 : count_r);
    if ($urandom_range(3) == 0 || span > 64'h0fff_ffff)
      p.t = TimeW'($urandom);
    else
      p.t = TimeW'($urandom_range(int'(span + span / 8)));
    p.tag  = ByteW'($urandom);
    p.refl = ByteW'($urandom);
    p.ring = ByteW'($urandom);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (hold_req) begin
        hold_cnt = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    slice_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pend_wr == pend_rd) begin
        $error("result word with nothing pending");
        failed = 1'b1;
      end else begin
        e = pend_mem[pend_rd % PendDepth];
        pend_rd++;
        check_field("keep", e.keep, out_if.keep);
        check_field("slice_index", e.sidx, out_if.slice_index);
        check_field("slice_fraction_q16", e.frac, out_if.slice_fraction_q16);
        check_field("out_x_mm", e.x[CoordW-1:0], out_if.out_x_mm[CoordW-1:0]);
        check_field("out_y_mm", e.y[CoordW-1:0], out_if.out_y_mm[CoordW-1:0]);
        check_field("out_z_mm", e.z[CoordW-1:0], out_if.out_z_mm[CoordW-1:0]);
        check_field("out_offset_ns", e.t, out_if.out_offset_ns);
        check_field("out_reflect", e.refl, out_if.out_reflect);
        check_field("out_ring", e.ring, out_if.out_ring);
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cnt = 0;
    else
      quiet_cnt++;
    if (quiet_cnt >= StallLimit) begin
      $display("lidar_point_filter_time_slicer_top test failed");
      $finish;
    end
  end

  vector_t vecs [NumVecs];

  function automatic point_t mk(bit f, int unsigned idx, int x, int y, int z, int unsigned t,
                                int unsigned tag, int unsigned refl, int unsigned ring);
    point_t p;
    p.finite = f;
    p.idx = IdxW'(idx);
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.z = CoordW'(z);
    p.t = TimeW'(t);
    p.tag = ByteW'(tag);
    p.refl = ByteW'(refl);
    p.ring = ByteW'(ring);
    return p;
  endfunction

  initial begin
    point_t p;
    int n;
    failed = 1'b0;
    hold_req = 1'b0;
    quiet_cnt = 0;
    pend_wr = 0;
    pend_rd = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_if.valid = 1'b0;
    in_if.coords_finite = 1'b0;
    in_if.point_index = '0;
    in_if.x_mm = '0;
    in_if.y_mm = '0;
    in_if.z_mm = '0;
    in_if.offset_ns = '0;
    in_if.tag_bits = '0;
    in_if.reflect_level = '0;
    in_if.ring_number = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    step_r = DecimateRst;
    min_r2_r = MinRangeRst;
    max_r2_r = MaxRangeRst;
    tag_en_r = 1'b0;
    count_r = CountRst;
    width_r = WidthRst;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: outcomes read straight off the rules
    vecs[0] = '{mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0, 0};
    vecs[1] = '{mk(0, 0, 5, 5, 5, 0, 0, 255, 255), 1, 0, 0, 0};
    vecs[2] = '{mk(1, 1048575, 262143, 262143, 262143, 0, 0, 0, 0), 1, 0, 0, 0};
    vecs[3] = '{mk(1, 3, -262144, 0, 0, 0, 255, 0, 0), 1, 0, 0, 0};
    vecs[4] = '{mk(1, 7, 150000, 0, 0, 268435455, 255, 255, 255), 1, 1, 0, FracSat};
    vecs[5] = '{mk(1, 1048575, 0, -150000, 0, 50000000, 48, 1, 1), 1, 1, 0, 32768};
    vecs[6] = '{mk(1, 9, 0, 0, 150001, 0, 0, 0, 0), 1, 0, 0, 0};
    vecs[7] = '{mk(1, 2, -1, -1, -1, 99999999, 0, 0, 0), 1, 1, 0, 65535};
    for (int i = 0; i < NumVecs; i++)
      send_point(vecs[i].p, vecs[i].known, vecs[i].keep, vecs[i].sidx, vecs[i].frac);
    drain();

    // zero step, count and width; tag check on
    write_all(8'd0, 40'd3, 40'hff_ffff_ffff, 1'b1, 5'd0, 28'd0);
    write_reg(RegSliceW + CfgIdxW'(1), '1);
    for (int tg = 0; tg < 4; tg++)
      send_point(mk(1, 5 + tg, 1, 1, tg, 1000, tg << 4, tg, tg), 0, 0, 0, 0);
    send_point(mk(1, 5, 1, 1, 0, 1000, 0, 0, 0), 0, 0, 0, 0);
    send_point(mk(1, 5, 1, 0, 0, 1000, 0, 0, 0), 0, 0, 0, 0);
    drain();

    // widest step, count past the limit, smallest width
    write_all(8'd255, 40'd0, 40'hff_ffff_ffff, 1'b0, 5'd31, 28'd1);
    send_point(mk(1, 255, 0, 0, 0, 7, 0, 0, 0), 0, 0, 0, 0);
    send_point(mk(1, 254, 0, 0, 0, 7, 0, 0, 0), 0, 0, 0, 0);
    send_point(mk(1, 1020, 0, 0, 0, 15, 0, 0, 0), 0, 0, 0, 0);
    send_point(mk(1, 0, 0, 0, 0, 268435455, 0, 0, 0), 0, 0, 0, 0);
    drain();
    write_all(8'd1, 40'd0, 40'hff_ffff_ffff, 1'b0, 5'd16, 28'd268435455);
    send_point(mk(1, 0, 0, 0, 0, 268435455, 0, 0, 0), 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_all(ph == 9 ? 8'd255 : ($urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(4))),
                $urandom_range(1) ? 40'd0 : 40'($urandom_range(400000000)),
                ph == 5 ? 40'hff_ffff_ffff : 40'({$urandom, $urandom}) % 40'd30000000000,
                1'($urandom), 5'($urandom),
                ph == 7 ? 28'd268435455 : ($urandom_range(1) ? 28'($urandom_range(1, 300))
                                                            : 28'($urandom)));
      if (ph == 0) hold_req = 1'b1;
      n = RandomItems / 10;
      for (int i = 0; i < n; i++) begin
        p = rand_point();
        send_point(p, 0, 0, 0, 0);
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (!failed)
      $display("lidar_point_filter_time_slicer_top test passed");
    else
      $display("lidar_point_filter_time_slicer_top test failed");
    $finish;
  end

endmodule
